// ----- rtl/periodic_task_scheduler_tick_macros.svh -----
// Assertion macros for the periodic task scheduler
`ifndef PERIODIC_TASK_SCHEDULER_TICK_MACROS_SVH
`define PERIODIC_TASK_SCHEDULER_TICK_MACROS_SVH
`ifndef SYNTHESIS
`define PTS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);
`define PTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define PTS_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg)
`define PTS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ----- rtl/pts_pkg.sv -----
`timescale 1ns / 1ps
package pts_pkg;
	localparam int MaxTasks = 16;
	localparam int IdxW = 4;
	localparam logic [31:0] TimeMax = 32'hFFFF_FFFF;

	localparam logic [1:0] OpClear = 2'd0;
	localparam logic [1:0] OpLoad = 2'd1;
	localparam logic [1:0] OpTick = 2'd2;

	localparam logic [1:0] PolEdf = 2'd0;
	localparam logic [1:0] PolLlf = 2'd1;
	localparam logic [1:0] PolRm = 2'd2;

	localparam logic [1:0] StOk = 2'd0;
	localparam logic [1:0] StOvf = 2'd1;
	localparam logic [1:0] StIgnored = 2'd2;
	localparam logic [1:0] StBadLoad = 2'd3;

	localparam logic CfgPolicy = 1'b0;
	localparam logic CfgTaskCount = 1'b1;

	// gcd unit handshake
	typedef struct packed {
		logic start;
		logic [31:0] a;
		logic [15:0] b;
	} gcd_req_t;

	typedef struct packed {
		logic busy;
		logic done;
		logic [15:0] g;
	} gcd_rsp_t;
endpackage

// ----- rtl/pts_gcd.sv -----
`timescale 1ns / 1ps
`include "periodic_task_scheduler_tick_macros.svh"
// Euclid gcd, one remainder bit per cycle (restoring), shared by load.
module pts_gcd (
	input logic clk,
	input logic arst_n,
	input pts_pkg::gcd_req_t req,
	output pts_pkg::gcd_rsp_t rsp
);
	typedef enum logic [2:0] {
		G_IDLE = 3'b001,
		G_DIV = 3'b010,
		G_DONE = 3'b100
	} gstate_t;

	gstate_t st_q;
	logic [31:0] num_q;   // dividend shifting out
	logic [15:0] rem_q;
	logic [15:0] dvs_q;
	logic [5:0] cnt_q;
	logic [16:0] trial;
	logic [15:0] rnext;

	assign trial = {rem_q, num_q[31]} - {1'b0, dvs_q};
	assign rnext = trial[16] ? {rem_q[14:0], num_q[31]} : trial[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= G_IDLE;
			cnt_q <= '0;
		end else begin
			case (st_q)
				G_IDLE: begin
					if (req.start) begin
						num_q <= req.a;
						dvs_q <= req.b;
						rem_q <= '0;
						cnt_q <= 6'd32;
						st_q <= G_DIV;
					end
				end
				G_DIV: begin
					if (dvs_q == 16'd0) begin
						st_q <= G_DONE;
					end else if (cnt_q == 6'd0) begin
						// a mod b done: swap, old divisor goes to the top half
						num_q <= {dvs_q, 16'd0};
						dvs_q <= rem_q;
						rem_q <= '0;
						cnt_q <= 6'd16;
					end else begin
						rem_q <= rnext;
						num_q <= {num_q[30:0], 1'b0};
						cnt_q <= cnt_q - 6'd1;
					end
				end
				G_DONE: st_q <= G_IDLE;
				default: st_q <= G_IDLE;
			endcase
		end
	end

	assign rsp.busy = (st_q != G_IDLE);
	assign rsp.done = (st_q == G_DONE);
	assign rsp.g = num_q[31:16];

	`PTS_ASSERT_NEXT(a_gcd_start, clk, arst_n, req.start && st_q == G_IDLE, st_q == G_DIV, "no go")
	`PTS_ASSERT_NEXT(a_gcd_done, clk, arst_n, st_q == G_DONE, st_q == G_IDLE, "gcd done held")
	`PTS_ASSERT_IMPL(a_gcd_nz, clk, arst_n, st_q == G_DONE, num_q[15:0] == 16'd0, "gcd wide")
endmodule

// ----- rtl/periodic_task_scheduler_tick.sv -----
`timescale 1ns / 1ps
`include "periodic_task_scheduler_tick_macros.svh"
// Periodic task scheduler. Raise start with op and the load fields; the item is
// taken at the edge where busy is low. One result item appears for exactly one
// cycle, marked by done, and cannot be stalled: the receiver must take it then.
// A clear passes through a clearing state before the done cycle; a bad load,
// an ignored tick or an unknown op goes straight to it. A load runs the
// bit-serial Euclid gcd, the bit-serial divide of the hyperperiod by the gcd
// and the shift-add multiply; a tick walks one task per cycle through the
// release, expiry and selection passes, and through the leftover pass too on
// the tick that reaches the hyperperiod. Policy and task_count should be
// written only while busy is low.
module periodic_task_scheduler_tick (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic cfg_we,
	input logic cfg_index,
	input logic [4:0] cfg_wdata,
	input logic [1:0] op,
	input logic [3:0] task_index,
	input logic [15:0] task_period,
	input logic [15:0] relative_deadline,
	input logic [15:0] exec_time,
	input logic [15:0] pred_mask,
	output logic done,
	output logic run_valid,
	output logic [3:0] run_task,
	output logic [5:0] tick_misses,
	output logic [31:0] total_misses,
	output logic [31:0] current_time,
	output logic [31:0] hyperperiod,
	output logic finished,
	output logic schedulable,
	output logic [1:0] status
);
	localparam int N = pts_pkg::MaxTasks;

	typedef enum logic [10:0] {
		S_IDLE = 11'b00000000001,
		S_CLR = 11'b00000000010,
		S_GCD = 11'b00000000100,
		S_GWAIT = 11'b00000001000,
		S_MUL = 11'b00000010000,
		S_REL = 11'b00000100000,
		S_EXP = 11'b00001000000,
		S_SEL = 11'b00010000000,
		S_RUN = 11'b00100000000,
		S_END = 11'b01000000000,
		S_OUT = 11'b10000000000
	} state_t;

	state_t st_q;
	logic [1:0] policy_q;
	logic [4:0] tcount_q;

	logic [15:0] per_q [N];
	logic [15:0] dl_q [N];
	logic [15:0] ex_q [N];
	logic [15:0] pm_q [N];
	logic [31:0] absd_q [N];
	logic [15:0] rem_q [N];
	logic [N-1:0] act_q;
	logic [N-1:0] dn_q;
	logic [15:0] cd_q [N];

	logic [31:0] time_q;
	logic [31:0] miss_q;
	logic [31:0] lcm_q;
	logic [6:0] tmiss_q;
	logic [4:0] i_q;
	logic [4:0] n_q;
	logic best_v_q;
	logic [3:0] best_q;
	logic [1:0] st_out_q;
	logic rv_q;
	logic [31:0] shown_q;
	logic [15:0] lper_q;

	// lcm multiply: q * per, shift-add over 16 bits of per
	logic [31:0] q_q;
	logic [47:0] prod_q;
	logic [15:0] mb_q;
	logic [4:0] mcnt_q;

	pts_pkg::gcd_req_t greq;
	pts_pkg::gcd_rsp_t grsp;
	pts_gcd u_gcd (.clk(clk), .arst_n(arst_n), .req(greq), .rsp(grsp));

	// q = lcm / g via restoring divider sharing the gcd shape would be long;
	// instead divide here bit-serially
	logic [31:0] dnum_q;
	logic [15:0] drem_q;
	logic [15:0] dg_q;
	logic [16:0] dtrial;
	assign dtrial = {drem_q, dnum_q[31]} - {1'b0, dg_q};

	logic [3:0] ii;
	assign ii = i_q[3:0];
	logic unf_i;
	assign unf_i = act_q[ii] && !dn_q[ii] && (rem_q[ii] != 16'd0);

	logic [N-1:0] blk;
	logic ready_i;
	logic better;
	logic [32:0] s1, s2;
	always_comb begin
		for (int k = 0; k < N; k++)
			blk[k] = pm_q[ii][k] && (5'(k) < n_q) && act_q[k] && !dn_q[k];
		ready_i = unf_i && (policy_q <= pts_pkg::PolRm) && (blk == '0);
		s1 = {1'b0, absd_q[ii]} + {17'd0, rem_q[best_q]};
		s2 = {1'b0, absd_q[best_q]} + {17'd0, rem_q[ii]};
		case (policy_q)
			pts_pkg::PolEdf: better = absd_q[ii] < absd_q[best_q];
			pts_pkg::PolLlf: better = s1 < s2;
			default: better = per_q[ii] < per_q[best_q];
		endcase
	end

	logic [32:0] dsum;
	assign dsum = {1'b0, time_q} + {17'd0, dl_q[ii]};
	logic [15:0] cdn;
	assign cdn = (cd_q[ii] == 16'd0) ? per_q[ii] : cd_q[ii];
	logic rel_i;
	assign rel_i = (cd_q[ii] == 16'd0);
	logic [32:0] mtot;
	assign mtot = {1'b0, miss_q} + {26'd0, tmiss_q};

	always_comb begin
		greq.start = (st_q == S_GCD);
		greq.a = lcm_q;
		greq.b = lper_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_IDLE;
			policy_q <= pts_pkg::PolEdf;
			tcount_q <= 5'd1;
			act_q <= '0;
			dn_q <= '0;
			time_q <= '0;
			miss_q <= '0;
			lcm_q <= 32'd1;
			for (int k = 0; k < N; k++) begin
				absd_q[k] <= '0;
				rem_q[k] <= '0;
				cd_q[k] <= '0;
			end
		end else begin
			if (cfg_we) begin
				if (cfg_index == pts_pkg::CfgPolicy) policy_q <= cfg_wdata[1:0];
				else tcount_q <= cfg_wdata;
			end
			case (st_q)
				S_IDLE: begin
					if (start) begin
						st_out_q <= pts_pkg::StOk;
						rv_q <= 1'b0;
						best_q <= '0;
						best_v_q <= 1'b0;
						tmiss_q <= '0;
						shown_q <= time_q;
						i_q <= '0;
						n_q <= (tcount_q > 5'(N)) ? 5'(N) : tcount_q;
						case (op)
							pts_pkg::OpClear: st_q <= S_CLR;
							pts_pkg::OpLoad: begin
								if (task_period == 16'd0) begin
									st_out_q <= pts_pkg::StBadLoad;
									st_q <= S_OUT;
								end else begin
									per_q[task_index] <= task_period;
									dl_q[task_index] <= relative_deadline;
									ex_q[task_index] <= exec_time;
									pm_q[task_index] <= pred_mask;
									lper_q <= task_period;
									if (lcm_q == pts_pkg::TimeMax) begin
										st_out_q <= pts_pkg::StOvf;
										st_q <= S_OUT;
									end else st_q <= S_GCD;
								end
							end
							pts_pkg::OpTick: begin
								if (time_q >= lcm_q) begin
									st_out_q <= pts_pkg::StIgnored;
									st_q <= S_OUT;
								end else st_q <= S_REL;
							end
							default: st_q <= S_OUT;
						endcase
					end
				end
				S_CLR: begin
					act_q <= '0;
					dn_q <= '0;
					time_q <= '0;
					miss_q <= '0;
					lcm_q <= 32'd1;
					shown_q <= '0;
					for (int k = 0; k < N; k++) begin
						per_q[k] <= '0;
						dl_q[k] <= '0;
						ex_q[k] <= '0;
						pm_q[k] <= '0;
						absd_q[k] <= '0;
						rem_q[k] <= '0;
						cd_q[k] <= '0;
					end
					st_q <= S_OUT;
				end
				S_GCD: st_q <= S_GWAIT;
				S_GWAIT: begin
					if (grsp.done) begin
						dnum_q <= lcm_q;
						drem_q <= '0;
						dg_q <= grsp.g;
						mcnt_q <= 5'd0;
						q_q <= '0;
						i_q <= 5'd0;
						st_q <= S_MUL;
						mb_q <= lper_q;
						prod_q <= '0;
					end
				end
				S_MUL: begin
					// first q = lcm / g by the bit-serial divide; then the shift-add multiply
					if (mcnt_q == 5'd0) begin
						drem_q <= dtrial[16] ? {drem_q[14:0], dnum_q[31]} : dtrial[15:0];
						dnum_q <= {dnum_q[30:0], 1'b0};
						q_q <= {q_q[30:0], ~dtrial[16]};
						if (i_q == 5'd31) mcnt_q <= 5'd1;
						i_q <= i_q + 5'd1;
					end else if (mcnt_q <= 5'd16) begin
						if (mb_q[15]) prod_q <= {prod_q[46:0], 1'b0} + {16'd0, q_q};
						else prod_q <= {prod_q[46:0], 1'b0};
						mb_q <= {mb_q[14:0], 1'b0};
						mcnt_q <= mcnt_q + 5'd1;
					end else begin
						if (prod_q[47:32] != 16'd0 || prod_q[31:0] == pts_pkg::TimeMax) begin
							lcm_q <= pts_pkg::TimeMax;
							st_out_q <= pts_pkg::StOvf;
						end else lcm_q <= prod_q[31:0];
						st_q <= S_OUT;
					end
				end
				S_REL: begin
					if (i_q >= n_q) begin
						i_q <= '0;
						st_q <= S_EXP;
					end else begin
						if (rel_i) begin
							if (unf_i) tmiss_q <= tmiss_q + 7'd1;
							absd_q[ii] <= dsum[32] ? pts_pkg::TimeMax : dsum[31:0];
							rem_q[ii] <= ex_q[ii];
							act_q[ii] <= 1'b1;
							dn_q[ii] <= 1'b0;
						end
						cd_q[ii] <= (cdn == 16'd0) ? 16'd0 : cdn - 16'd1;
						i_q <= i_q + 5'd1;
					end
				end
				S_EXP: begin
					if (i_q >= n_q) begin
						i_q <= '0;
						st_q <= S_SEL;
					end else begin
						if (unf_i && time_q >= absd_q[ii]) begin
							tmiss_q <= tmiss_q + 7'd1;
							dn_q[ii] <= 1'b1;
						end
						i_q <= i_q + 5'd1;
					end
				end
				S_SEL: begin
					if (i_q >= n_q) begin
						st_q <= S_RUN;
					end else begin
						if (ready_i && (!best_v_q || better)) begin
							best_q <= ii;
							best_v_q <= 1'b1;
						end
						i_q <= i_q + 5'd1;
					end
				end
				S_RUN: begin
					if (best_v_q) begin
						rem_q[best_q] <= rem_q[best_q] - 16'd1;
						if (rem_q[best_q] == 16'd1) dn_q[best_q] <= 1'b1;
						rv_q <= 1'b1;
					end
					time_q <= time_q + 32'd1;
					i_q <= '0;
					st_q <= S_END;
				end
				S_END: begin
					if (time_q < lcm_q || i_q >= n_q) begin
						st_q <= S_OUT;
						miss_q <= mtot[32] ? 32'hFFFF_FFFF : mtot[31:0];
					end else begin
						if (unf_i) tmiss_q <= tmiss_q + 7'd1;
						i_q <= i_q + 5'd1;
					end
				end
				S_OUT: st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	assign busy = (st_q != S_IDLE);
	assign done = (st_q == S_OUT);
	assign run_valid = rv_q;
	assign run_task = rv_q ? best_q : 4'd0;
	assign tick_misses = (tmiss_q > 7'd63) ? 6'd63 : tmiss_q[5:0];
	assign total_misses = miss_q;
	assign current_time = shown_q;
	assign hyperperiod = lcm_q;
	assign finished = (time_q >= lcm_q);
	assign schedulable = (time_q >= lcm_q) && (miss_q == 32'd0);
	assign status = st_out_q;

	`PTS_ASSERT_NEXT(a_start_busy, clk, arst_n, start && !busy, busy, "start not taken")
	`PTS_ASSERT_NEXT(a_done_pulse, clk, arst_n, done, !done, "done longer than a cycle")
	`PTS_ASSERT_IMPL(a_lcm_nz, clk, arst_n, done, lcm_q != 32'd0, "hyperperiod zero")
endmodule

// ----- verif/tb_periodic_task_scheduler_tick.sv -----
`timescale 1ns / 1ps
module tb_periodic_task_scheduler_tick;
	// one result item as seen on the output ports
	typedef struct {
		logic run_valid;
		logic [3:0] run_task;
		logic [5:0] tick_misses;
		logic [31:0] total_misses;
		logic [31:0] current_time;
		logic [31:0] hyperperiod;
		logic finished;
		logic schedulable;
		logic [1:0] status;
	} sched_res_t;

	typedef enum logic {RowItem, RowCfg} row_kind_t;

	// directed table row; for config rows idx is the register index and per the data
	typedef struct {
		row_kind_t kind;
		logic [1:0] op;
		logic [3:0] idx;
		logic [15:0] per;
		logic [15:0] dl;
		logic [15:0] ex;
		logic [15:0] pm;
		bit typed;
		sched_res_t res;
	} dir_row_t;

	localparam longint unsigned TMAX = 64'hFFFF_FFFF;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [4:0] cfg_wdata = '0;
	logic [1:0] op = pts_pkg::OpClear;
	logic [3:0] task_index = '0;
	logic [15:0] task_period = '0;
	logic [15:0] relative_deadline = '0;
	logic [15:0] exec_time = '0;
	logic [15:0] pred_mask = '0;
	logic done;
	logic run_valid;
	logic [3:0] run_task;
	logic [5:0] tick_misses;
	logic [31:0] total_misses;
	logic [31:0] current_time;
	logic [31:0] hyperperiod;
	logic finished;
	logic schedulable;
	logic [1:0] status;

	periodic_task_scheduler_tick DUT (.*);

	initial begin
		forever #2 clk = ~clk;
	end

	// ---------------- scheduler shadow state ----------------
	logic [15:0] sh_period [16];
	logic [15:0] sh_deadline [16];
	logic [15:0] sh_exec [16];
	logic [15:0] sh_pred [16];
	longint unsigned sh_abs_dl [16];
	logic [15:0] sh_remain [16];
	bit sh_active [16];
	bit sh_done [16];
	logic [15:0] sh_countdown [16];
	longint unsigned sh_now;
	longint unsigned sh_lcm;
	logic [31:0] sh_miss_total;
	logic [1:0] sh_policy = pts_pkg::PolEdf;
	logic [4:0] sh_task_count = 5'd1;

	sched_res_t pending_results[$];
	int errors = 0;
	int items_sent = 0;
	int idle_pct = 29;

	function automatic bit job_open(int i);
		return sh_active[i] && !sh_done[i] && sh_remain[i] != 0;
	endfunction

	function automatic void shadow_clear();
		for (int i = 0; i < 16; i++) begin
			sh_period[i] = '0;
			sh_deadline[i] = '0;
			sh_exec[i] = '0;
			sh_pred[i] = '0;
			sh_abs_dl[i] = 0;
			sh_remain[i] = '0;
			sh_active[i] = 0;
			sh_done[i] = 0;
			sh_countdown[i] = '0;
		end
		sh_now = 0;
		sh_miss_total = '0;
		sh_lcm = 1;
	endfunction

	// advance the shadow scheduler by one item and return the result it implies
	function automatic sched_res_t schedule_step(logic [1:0] o, logic [3:0] idx,
			logic [15:0] per, logic [15:0] dl, logic [15:0] ex, logic [15:0] pm);
		sched_res_t r;
		int n;
		int best;
		int miss;
		bit ready;
		bit better;
		longint unsigned t, a, b, g, q, d;
		n = (sh_task_count < 16) ? int'(sh_task_count) : 16;
		best = -1;
		miss = 0;
		r.run_valid = 0;
		r.run_task = '0;
		r.status = pts_pkg::StOk;
		t = sh_now;
		if (o == pts_pkg::OpClear) begin
			shadow_clear();
			t = 0;
		end else if (o == pts_pkg::OpLoad) begin
			if (per == 0) begin
				r.status = pts_pkg::StBadLoad;
			end else begin
				sh_period[idx] = per;
				sh_deadline[idx] = dl;
				sh_exec[idx] = ex;
				sh_pred[idx] = pm;
				if (sh_lcm >= TMAX) begin
					sh_lcm = TMAX;
					r.status = pts_pkg::StOvf;
				end else begin
					a = sh_lcm;
					b = per;
					while (b != 0) begin
						g = a % b;
						a = b;
						b = g;
					end
					q = sh_lcm / a;
					if (q > TMAX / per) begin
						sh_lcm = TMAX;
						r.status = pts_pkg::StOvf;
					end else begin
						sh_lcm = q * per;
					end
				end
			end
		end else if (o == pts_pkg::OpTick && sh_now >= sh_lcm) begin
			r.status = pts_pkg::StIgnored;
		end else if (o == pts_pkg::OpTick) begin
			// release pass
			for (int i = 0; i < n; i++) begin
				if (sh_countdown[i] == 0) begin
					d = sh_deadline[i];
					if (job_open(i))
						miss++;
					sh_abs_dl[i] = (t > TMAX - d) ? TMAX : t + d;
					sh_remain[i] = sh_exec[i];
					sh_active[i] = 1;
					sh_done[i] = 0;
					sh_countdown[i] = sh_period[i];
				end
				if (sh_countdown[i] > 0)
					sh_countdown[i]--;
			end
			// expiry pass
			for (int i = 0; i < n; i++) begin
				if (job_open(i) && t >= sh_abs_dl[i]) begin
					miss++;
					sh_done[i] = 1;
				end
			end
			// pick: predecessors clear, then lowest priority value, lowest index on ties
			for (int i = 0; i < n; i++) begin
				ready = job_open(i) && sh_policy <= pts_pkg::PolRm;
				for (int k = 0; k < n; k++)
					if (sh_pred[i][k] && sh_active[k] && !sh_done[k])
						ready = 0;
				if (ready) begin
					if (best < 0) begin
						best = i;
					end else begin
						case (sh_policy)
							pts_pkg::PolEdf: better = sh_abs_dl[i] < sh_abs_dl[best];
							pts_pkg::PolLlf: better = sh_abs_dl[i] + sh_remain[best] <
									sh_abs_dl[best] + sh_remain[i];
							default: better = sh_period[i] < sh_period[best];
						endcase
						if (better)
							best = i;
					end
				end
			end
			if (best >= 0) begin
				sh_remain[best]--;
				if (sh_remain[best] == 0)
					sh_done[best] = 1;
				r.run_valid = 1;
				r.run_task = best[3:0];
			end
			sh_now = t + 1;
			if (sh_now >= sh_lcm)
				for (int i = 0; i < n; i++)
					if (job_open(i))
						miss++;
			sh_miss_total = (longint'(sh_miss_total) + miss > TMAX) ?
					32'hFFFF_FFFF : sh_miss_total + miss;
		end
		r.tick_misses = (miss > 63) ? 6'd63 : miss[5:0];
		r.total_misses = sh_miss_total;
		r.current_time = t[31:0];
		r.hyperperiod = sh_lcm[31:0];
		r.finished = sh_now >= sh_lcm;
		r.schedulable = (sh_now >= sh_lcm) && sh_miss_total == 0;
		return r;
	endfunction

	// ---------------- stimulus helpers ----------------
	task automatic send_item(logic [1:0] o, logic [3:0] idx, logic [15:0] per,
			logic [15:0] dl, logic [15:0] ex, logic [15:0] pm, bit typed,
			sched_res_t typed_res);
		sched_res_t r;
		start <= 1'b1;
		op <= o;
		task_index <= idx;
		task_period <= per;
		relative_deadline <= dl;
		exec_time <= ex;
		pred_mask <= pm;
		do
			@(posedge clk);
		while (busy);
		r = schedule_step(o, idx, per, dl, ex, pm);
		pending_results.insert(pending_results.size(), typed ? typed_res : r);
		items_sent++;
		if ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
		end
	endtask

	task automatic send_rand(logic [1:0] o, logic [3:0] idx, logic [15:0] per,
			logic [15:0] dl, logic [15:0] ex, logic [15:0] pm);
		sched_res_t nothing;
		send_item(o, idx, per, dl, ex, pm, 0, nothing);
	endtask

	// registers change only with the block idle and nothing outstanding
	task automatic write_reg(logic ridx, logic [4:0] val);
		start <= 1'b0;
		while (pending_results.size() != 0 || busy)
			@(posedge clk);
		repeat (4) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= ridx;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (ridx == pts_pkg::CfgPolicy)
			sh_policy = val[1:0];
		else
			sh_task_count = val;
	endtask

	// ---------------- result checking ----------------
	task automatic check_field(string name, logic [31:0] expv, logic [31:0] actv);
		if (expv !== actv) begin
			$display("%0t ERROR %s expected %0h actual %0h", $realtime, name, expv, actv);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		sched_res_t e;
		if (arst_n && done) begin
			if (pending_results.size() == 0) begin
				$display("%0t ERROR result with nothing expected", $realtime);
				errors++;
			end else begin
				e = pending_results.pop_front();
				check_field("run_valid", e.run_valid, run_valid);
				check_field("run_task", e.run_task, run_task);
				check_field("tick_misses", e.tick_misses, tick_misses);
				check_field("total_misses", e.total_misses, total_misses);
				check_field("current_time", e.current_time, current_time);
				check_field("hyperperiod", e.hyperperiod, hyperperiod);
				check_field("finished", e.finished, finished);
				check_field("schedulable", e.schedulable, schedulable);
				check_field("status", e.status, status);
			end
		end
	end

	// ---------------- directed table ----------------
	function automatic sched_res_t mk(logic rv, logic [3:0] rt, logic [31:0] tm,
			logic [31:0] hp, logic fin, logic sch, logic [1:0] st);
		sched_res_t r;
		r.run_valid = rv;
		r.run_task = rt;
		r.tick_misses = '0;
		r.total_misses = '0;
		r.current_time = tm;
		r.hyperperiod = hp;
		r.finished = fin;
		r.schedulable = sch;
		r.status = st;
		return r;
	endfunction

	dir_row_t dir_rows[$];

	function automatic void add_row(row_kind_t k, logic [1:0] o, logic [3:0] idx,
			logic [15:0] per, logic [15:0] dl, logic [15:0] ex, logic [15:0] pm,
			bit typed, sched_res_t r);
		dir_row_t row;
		row.kind = k;
		row.op = o;
		row.idx = idx;
		row.per = per;
		row.dl = dl;
		row.ex = ex;
		row.pm = pm;
		row.typed = typed;
		row.res = r;
		dir_rows.insert(dir_rows.size(), row);
	endfunction

	function automatic void build_table();
		sched_res_t z;
		z = mk(0, 0, 0, 1, 0, 0, pts_pkg::StOk);
		add_row(RowItem, pts_pkg::OpClear, 4'hF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
				1, z);
		// zero period is a bad load, nothing changes
		add_row(RowItem, pts_pkg::OpLoad, 0, 0, 5, 5, 0, 1,
				mk(0, 0, 0, 1, 0, 0, pts_pkg::StBadLoad));
		add_row(RowItem, pts_pkg::OpLoad, 0, 1, 1, 1, 0, 1, z);
		// one-tick hyperperiod: runs, then finishes clean
		add_row(RowItem, pts_pkg::OpTick, 0, 0, 0, 0, 0, 1,
				mk(1, 0, 0, 1, 1, 1, pts_pkg::StOk));
		// tick once finished is ignored
		add_row(RowItem, pts_pkg::OpTick, 0, 0, 0, 0, 0, 1,
				mk(0, 0, 1, 1, 1, 1, pts_pkg::StIgnored));
		add_row(RowItem, pts_pkg::OpLoad, 0, 16'hFFFF, 3, 2, 0, 0, z);
		add_row(RowCfg, 0, 4'(pts_pkg::CfgTaskCount), 3, 0, 0, 0, 0, z);
		// self-blocking, all ones predecessor mask
		add_row(RowItem, pts_pkg::OpLoad, 1, 16'hFFFE, 16'hFFFF, 16'hFFFF, 16'hFFFF, 0, z);
		// lcm overflow saturates and sticks until clear
		add_row(RowItem, pts_pkg::OpLoad, 2, 16'hFFFD, 0, 0, 0, 1,
				mk(0, 0, 1, 32'hFFFF_FFFF, 0, 0, pts_pkg::StOvf));
		add_row(RowItem, pts_pkg::OpLoad, 3, 1, 1, 1, 1, 1,
				mk(0, 0, 1, 32'hFFFF_FFFF, 0, 0, pts_pkg::StOvf));
		for (int i = 0; i < 3; i++)
			add_row(RowItem, pts_pkg::OpTick, 0, 0, 0, 0, 0, 0, z);
		add_row(RowCfg, 0, 4'(pts_pkg::CfgPolicy), 16'(pts_pkg::PolLlf), 0, 0, 0, 0, z);
		add_row(RowItem, pts_pkg::OpTick, 0, 0, 0, 0, 0, 0, z);
		add_row(RowItem, pts_pkg::OpTick, 0, 0, 0, 0, 0, 0, z);
		add_row(RowCfg, 0, 4'(pts_pkg::CfgPolicy), 16'(pts_pkg::PolRm), 0, 0, 0, 0, z);
		add_row(RowItem, pts_pkg::OpTick, 0, 0, 0, 0, 0, 0, z);
		add_row(RowItem, pts_pkg::OpTick, 0, 0, 0, 0, 0, 0, z);
		// unknown policy never runs anything
		add_row(RowCfg, 0, 4'(pts_pkg::CfgPolicy), 3, 0, 0, 0, 0, z);
		add_row(RowItem, pts_pkg::OpTick, 0, 0, 0, 0, 0, 0, z);
		// no tasks in use
		add_row(RowCfg, 0, 4'(pts_pkg::CfgTaskCount), 0, 0, 0, 0, 0, z);
		add_row(RowItem, pts_pkg::OpTick, 0, 0, 0, 0, 0, 0, z);
		add_row(RowItem, 2'd3, 4'h5, 16'h1234, 0, 0, 0, 0, z);
	endfunction

	// ---------------- main sequence ----------------
	initial begin
		int tc;
		int nused;
		int nticks;
		bit tiny;
		logic [1:0] pol;
		logic [15:0] per, dl, ex, pm;
		shadow_clear();
		build_table();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		foreach (dir_rows[i]) begin
			if (dir_rows[i].kind == RowCfg)
				write_reg(dir_rows[i].idx[0], dir_rows[i].per[4:0]);
			else
				send_item(dir_rows[i].op, dir_rows[i].idx, dir_rows[i].per,
						dir_rows[i].dl, dir_rows[i].ex, dir_rows[i].pm,
						dir_rows[i].typed, dir_rows[i].res);
		end

		// random task sets: clear, load every entry in use, then tick
		while (items_sent < 1900) begin
			idle_pct = (items_sent < 630) ? 29 : (items_sent < 1260) ? 88 : 0;
			pol = ($urandom_range(9) == 0) ? 2'd3 : 2'($urandom_range(2));
			case ($urandom_range(19))
				0: tc = 0;
				1: tc = 16;
				2: tc = 31;
				default: tc = $urandom_range(1, 6);
			endcase
			write_reg(pts_pkg::CfgPolicy, {3'b0, pol});
			write_reg(pts_pkg::CfgTaskCount, tc[4:0]);
			nused = (tc > 16) ? 16 : tc;
			tiny = $urandom_range(2) != 0;
			send_rand(pts_pkg::OpClear, 4'($urandom), 16'($urandom), 16'($urandom),
					16'($urandom), 16'($urandom));
			for (int i = 0; i < nused; i++) begin
				if ($urandom_range(9) == 0)
					send_rand(pts_pkg::OpLoad, 4'($urandom), 0, 16'($urandom),
							16'($urandom), 16'($urandom));
				if (tiny)
					per = 16'($urandom_range(1, 4));
				else if ($urandom_range(7) == 0)
					per = 16'($urandom_range(1, 65535));
				else
					per = 16'($urandom_range(1, 12));
				dl = ($urandom_range(9) == 0) ? 16'($urandom) :
						16'($urandom_range(0, int'(per) + 2));
				ex = ($urandom_range(19) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
				pm = ($urandom_range(3) == 0) ? 16'($urandom) :
						16'($urandom & $urandom & $urandom);
				send_rand(pts_pkg::OpLoad, 4'(i), per, dl, ex, pm);
			end
			if (tiny && sh_lcm <= 60)
				nticks = int'(sh_lcm) + $urandom_range(0, 3);
			else
				nticks = $urandom_range(5, 40);
			for (int t = 0; t < nticks; t++) begin
				if ($urandom_range(49) == 0)
					send_rand(2'd3, 4'($urandom), 16'($urandom), 0, 0, 0);
				send_rand(pts_pkg::OpTick, 4'($urandom), 16'($urandom), 16'($urandom),
						16'($urandom), 16'($urandom));
			end
		end

		start <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0 && pending_results.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	// watchdog, well beyond the slowest legal run
	initial begin
		#40_000_000;
		$display("Some tests failed");
		$finish;
	end
endmodule

// ----- sim.f -----
+incdir+rtl
rtl/pts_pkg.sv
rtl/pts_gcd.sv
rtl/periodic_task_scheduler_tick.sv
verif/tb_periodic_task_scheduler_tick.sv
